// ===== sv/indexed_array_insert_remove_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed array block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_INSERT_REMOVE_TOP_MACROS_SVH
`define INDEXED_ARRAY_INSERT_REMOVE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define IAI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed array check failed");
`define IAI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed array check failed");
`else
`define IAI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IAI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/iai_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed array package
// Request kinds, status codes and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package iai_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_READ   = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_TRUNC  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BAD  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    // Command seen by every cell in the row in the same cycle.
    typedef struct packed {
        cell_op_t    op;
        logic [15:0] pos;
        logic [15:0] fill;
    } cell_cmd_t;

endpackage

// ===== sv/iai_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed array cell
// Holds one element and loads it from the request or from a neighbor.
// ----------------------------------------------------------------------------
module iai_cell #(
    parameter int DATA_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          idx,
    input  iai_pkg::cell_cmd_t   cmd,
    input  logic [DATA_W-1:0]    new_data,
    input  logic [DATA_W-1:0]    lower_data,
    input  logic [DATA_W-1:0]    upper_data,
    output logic [DATA_W-1:0]    data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_pos;
    logic              above_pos;
    logic              at_or_below_fill;
    logic              below_top;

    assign at_pos           = (idx == cmd.pos);
    assign above_pos        = (idx > cmd.pos);
    assign at_or_below_fill = (idx <= cmd.fill);
    assign below_top        = (({1'b0, idx} + 17'd1) < {1'b0, cmd.fill});

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            iai_pkg::CELL_WRITE:
            begin
                if (at_pos)
                begin
                    data_next = new_data;
                end
            end
            iai_pkg::CELL_INSERT:
            begin
                // Cells from the slot up to the old count move up by one.
                if (at_pos)
                begin
                    data_next = new_data;
                end
                else if (above_pos && at_or_below_fill)
                begin
                    data_next = lower_data;
                end
            end
            iai_pkg::CELL_REMOVE:
            begin
                // The old top entry keeps its stale value.
                if ((at_pos || above_pos) && below_top)
                begin
                    data_next = upper_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ===== sv/indexed_array_insert_remove_top.sv =====
// Output: the result of an accepted request is registered for the next cycle.
// Throughput: one request per cycle while the output is not stalled; the
// row of element cells shifts a whole insert or remove as the request is accepted.
// Reset: asynchronous, clears every element, the fill count and the output.
// ----------------------------------------------------------------------------
// Indexed array insert and remove
// Fixed-capacity element store with a fill count, built as a row of cells.
// ----------------------------------------------------------------------------
`include "indexed_array_insert_remove_top_macros.svh"

module indexed_array_insert_remove_top #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         kind,
    input  logic signed [15:0]                 index,
    input  logic [31:0]                        write_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [31:0]                        read_data,
    output logic [$clog2(CAPACITY+1)-1:0]      fill_count_out
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;
    localparam logic [15:0] CAP16 = 16'(CAPACITY);

    logic [DATA_W-1:0]  cell_data [CAPACITY];
    iai_pkg::cell_cmd_t cmd;

    logic                 out_valid_reg;
    iai_pkg::status_t     status_reg;
    iai_pkg::status_t     status_next;
    logic [31:0]          read_data_reg;
    logic [31:0]          read_data_next;
    logic [CNT_W-1:0]     fill_out_reg;
    logic [CNT_W-1:0]     fill_count_reg;
    logic [CNT_W-1:0]     fill_count_next;

    logic                 accept;
    logic [15:0]          pos;
    logic [15:0]          fill16;
    logic                 neg;
    logic                 past_fill;
    logic                 past_cap;
    logic [DATA_W-1:0]    new_data;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign neg      = index[15];
    assign pos      = 16'(index);
    assign fill16   = 16'(fill_count_reg);
    assign past_fill = (pos >= fill16);
    assign past_cap  = (pos >= CAP16);
    assign new_data  = write_data[DATA_W-1:0];

    always_comb
    begin
        status_next     = iai_pkg::STATUS_OK;
        read_data_next  = '0;
        fill_count_next = fill_count_reg;
        cmd.op          = iai_pkg::CELL_HOLD;
        cmd.pos         = pos;
        cmd.fill        = fill16;
        if (kind <= iai_pkg::KIND_TRUNC && neg)
        begin
            status_next = iai_pkg::STATUS_BAD;
        end
        else
        begin
            case (kind) inside
                iai_pkg::KIND_WRITE,
                iai_pkg::KIND_INSERT:
                begin
                    // An insert at or above the count acts as a plain write.
                    if (kind == iai_pkg::KIND_WRITE || past_fill)
                    begin
                        if (past_cap)
                        begin
                            status_next = iai_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cmd.op = iai_pkg::CELL_WRITE;
                            if (past_fill)
                            begin
                                fill_count_next = CNT_W'(pos + 16'd1);
                            end
                        end
                    end
                    else if (fill16 == CAP16)
                    begin
                        status_next = iai_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.op          = iai_pkg::CELL_INSERT;
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                end
                iai_pkg::KIND_READ:
                begin
                    if (past_fill)
                    begin
                        status_next = iai_pkg::STATUS_BAD;
                    end
                    else
                    begin
                        read_data_next = 32'(cell_data[pos[IDX_W-1:0]]);
                    end
                end
                iai_pkg::KIND_REMOVE:
                begin
                    if (past_fill)
                    begin
                        status_next = iai_pkg::STATUS_BAD;
                    end
                    else
                    begin
                        cmd.op          = iai_pkg::CELL_REMOVE;
                        fill_count_next = fill_count_reg - CNT_W'(1);
                    end
                end
                iai_pkg::KIND_TRUNC:
                begin
                    if (!past_fill)
                    begin
                        fill_count_next = CNT_W'(pos);
                    end
                end
                default:
                begin
                    status_next = iai_pkg::STATUS_OK;
                end
            endcase
        end
        if (!accept)
        begin
            cmd.op = iai_pkg::CELL_HOLD;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        if (i == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = cell_data[i+1];
        end
        iai_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (16'(i)),
            .cmd        (cmd),
            .new_data   (new_data),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= iai_pkg::STATUS_OK;
            read_data_reg  <= '0;
            fill_out_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
                out_valid_reg  <= 1'b1;
                status_reg     <= status_next;
                read_data_reg  <= read_data_next;
                fill_out_reg   <= fill_count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_data      = read_data_reg;
    assign fill_count_out = fill_out_reg;

    `IAI_ASSERT_SAME(a_fill_in_range, clk, rst_n, 1'b1, fill_count_reg <= CNT_W'(CAPACITY))
    `IAI_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)
    `IAI_ASSERT_SAME(a_count_matches, clk, rst_n, out_valid_reg, fill_out_reg == fill_count_reg)
    `IAI_ASSERT_SAME(a_data_only_ok, clk, rst_n, out_valid_reg && read_data_reg != '0, status_reg == iai_pkg::STATUS_OK)

endmodule

// ===== verif/array_op_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed array result checker
// Watches both channels of the indexed array block. It keeps its own copy of
// the element store and fill count, works out the result of every accepted
// request and compares each returned result with the oldest one pending.
// ----------------------------------------------------------------------------
module array_op_checker #(
    parameter int CAPACITY = 64,
    parameter int COUNT_W  = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [2:0]          kind,
    input  logic signed [15:0]  index,
    input  logic [31:0]         write_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          status,
    input  logic [31:0]         read_data,
    input  logic [COUNT_W-1:0]  fill_count_out,
    output int                  error_count,
    output int                  pending_count
);

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        data;
        logic [COUNT_W-1:0] fill;
    } array_result_t;

    logic [31:0]   elements [CAPACITY];
    int            live_count;
    array_result_t expected_results [$];

    function automatic logic [1:0] store_element(int pos, logic [31:0] data);
        if (pos >= CAPACITY)
        begin
            return iai_pkg::STATUS_FULL;
        end
        elements[pos] = data;
        if (pos >= live_count)
        begin
            live_count = pos + 1;
        end
        return iai_pkg::STATUS_OK;
    endfunction

    function automatic array_result_t predict_result(logic [2:0] op,
                                                     logic signed [15:0] idx,
                                                     logic [31:0] data);
        array_result_t res;
        int            pos;
        res.status = iai_pkg::STATUS_OK;
        res.data   = '0;
        pos        = idx;
        if (op <= iai_pkg::KIND_TRUNC && pos < 0)
        begin
            res.status = iai_pkg::STATUS_BAD;
        end
        else
        begin
            case (op)
                iai_pkg::KIND_WRITE:
                begin
                    res.status = store_element(pos, data);
                end
                iai_pkg::KIND_INSERT:
                begin
                    // Inserting at or past the end is the same as a write.
                    if (pos >= live_count)
                    begin
                        res.status = store_element(pos, data);
                    end
                    else if (live_count >= CAPACITY)
                    begin
                        res.status = iai_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        for (int i = live_count; i > pos; i--)
                        begin
                            elements[i] = elements[i-1];
                        end
                        elements[pos] = data;
                        live_count++;
                    end
                end
                iai_pkg::KIND_READ:
                begin
                    if (pos >= live_count)
                    begin
                        res.status = iai_pkg::STATUS_BAD;
                    end
                    else
                    begin
                        res.data = elements[pos];
                    end
                end
                iai_pkg::KIND_REMOVE:
                begin
                    // The old top entry is left stale.
                    if (pos >= live_count)
                    begin
                        res.status = iai_pkg::STATUS_BAD;
                    end
                    else
                    begin
                        for (int i = pos; i + 1 < live_count; i++)
                        begin
                            elements[i] = elements[i+1];
                        end
                        live_count--;
                    end
                end
                iai_pkg::KIND_TRUNC:
                begin
                    if (pos < live_count)
                    begin
                        live_count = pos;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.fill = COUNT_W'(live_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        array_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                elements[i] = '0;
            end
            live_count = 0;
            expected_results.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            // A result never belongs to the request taken at the same edge,
            // so it is checked before that request is predicted.
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d data %h fill %0d",
                             $time, status, read_data, fill_count_out);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, status);
                        error_count++;
                    end
                    if (read_data !== want.data)
                    begin
                        $display("%0t: read_data expected %h, got %h",
                                 $time, want.data, read_data);
                        error_count++;
                    end
                    if (fill_count_out !== want.fill)
                    begin
                        $display("%0t: fill_count_out expected %0d, got %0d",
                                 $time, want.fill, fill_count_out);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_result(kind, index, write_data));
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed array testbench
// Drives directed corner requests and then biased random requests through
// phases of sender gaps and receiver stalls, including a long output hold.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         CAPACITY         = 64;
    localparam int         COUNT_W          = $clog2(CAPACITY + 1);
    localparam int         RANDOM_PER_PHASE = 500;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [2:0]         kind       = '0;
    logic signed [15:0] index      = '0;
    logic [31:0]        write_data = '0;
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [1:0]         status;
    logic [31:0]        read_data;
    logic [COUNT_W-1:0] fill_count_out;

    int error_count;
    int pending_count;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    bit hold_req      = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    indexed_array_insert_remove_top #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (32)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .index          (index),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .fill_count_out (fill_count_out)
    );

    array_op_checker #(
        .CAPACITY (CAPACITY),
        .COUNT_W  (COUNT_W)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .index          (index),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .fill_count_out (fill_count_out),
        .error_count    (error_count),
        .pending_count  (pending_count)
    );

    // Receiver side: random stalls, or a long hold when one is asked for.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Entered and left at a falling edge.
    task automatic send_request(logic [2:0] op, logic signed [15:0] idx,
                                logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        index      <= idx;
        write_data <= data;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Growing stretches favor inserts and writes so the store fills up;
    // shrinking stretches favor removes and truncates.
    task automatic random_request(bit grow);
        logic [2:0]         op;
        logic signed [15:0] idx;
        logic [31:0]        data;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 3)
            op = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
        else if (grow)
            op = roll < 45 ? iai_pkg::KIND_INSERT : roll < 70 ? iai_pkg::KIND_WRITE :
                 roll < 88 ? iai_pkg::KIND_READ : roll < 96 ? iai_pkg::KIND_REMOVE :
                 iai_pkg::KIND_TRUNC;
        else
            op = roll < 15 ? iai_pkg::KIND_INSERT : roll < 25 ? iai_pkg::KIND_WRITE :
                 roll < 55 ? iai_pkg::KIND_READ : roll < 90 ? iai_pkg::KIND_REMOVE :
                 iai_pkg::KIND_TRUNC;
        roll = $urandom_range(99);
        if (roll < 4)
            idx = {1'b1, 15'($urandom)};
        else if (roll < 8)
            idx = {1'b0, 15'($urandom)};
        else
            idx = 16'($urandom_range(CAPACITY + 2));
        roll = $urandom_range(99);
        data = roll < 5 ? 32'h0 : roll < 10 ? 32'hFFFF_FFFF : $urandom;
        send_request(op, idx, data);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty store, negative indexes, then a write that fills it at once.
        send_request(iai_pkg::KIND_READ,   16'sd0,      32'h1111_1111);
        send_request(iai_pkg::KIND_REMOVE, 16'sd0,      32'h0);
        send_request(iai_pkg::KIND_WRITE,  -16'sd32768, 32'hDEAD_BEEF);
        send_request(iai_pkg::KIND_INSERT, -16'sd1,     32'h0BAD_0BAD);
        send_request(iai_pkg::KIND_TRUNC,  -16'sd1,     32'h0);
        send_request(iai_pkg::KIND_WRITE,  16'sd63,     32'hFFFF_FFFF);
        send_request(iai_pkg::KIND_READ,   16'sd10,     32'h0);
        send_request(iai_pkg::KIND_READ,   16'sd63,     32'h0);
        // Full store and writes past capacity.
        send_request(iai_pkg::KIND_WRITE,  16'sd64,     32'h1234_5678);
        send_request(iai_pkg::KIND_WRITE,  16'sd32767,  32'h8765_4321);
        send_request(iai_pkg::KIND_INSERT, 16'sd5,      32'hA5A5_A5A5);
        send_request(iai_pkg::KIND_INSERT, 16'sd64,     32'h5A5A_5A5A);
        send_request(iai_pkg::KIND_REMOVE, 16'sd0,      32'h0);
        send_request(iai_pkg::KIND_READ,   16'sd63,     32'h0);
        send_request(iai_pkg::KIND_INSERT, 16'sd0,      32'h1234_5678);
        send_request(iai_pkg::KIND_READ,   16'sd0,      32'h0);
        send_request(iai_pkg::KIND_REMOVE, 16'sd63,     32'h0);
        // Truncate above the count and then to two entries, then a write that leaves stale cells.
        send_request(iai_pkg::KIND_TRUNC,  16'sd100,    32'h0);
        send_request(iai_pkg::KIND_TRUNC,  16'sd2,      32'h0);
        send_request(iai_pkg::KIND_WRITE,  16'sd10,     32'h5555_5555);
        send_request(iai_pkg::KIND_READ,   16'sd5,      32'h0);
        send_request(iai_pkg::KIND_INSERT, 16'sd11,     32'hAAAA_AAAA);
        send_request(KIND_SPARE_FIRST, 16'sd3, 32'hFFFF_FFFF);
        send_request(KIND_SPARE_LAST,  -16'sd1, 32'hFFFF_FFFF);
        send_request(iai_pkg::KIND_TRUNC,  16'sd0,      32'h0);
        send_request(iai_pkg::KIND_READ,   16'sd0,      32'h0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 49 : (phase == 3) ? 22 : 0;
            stall_pct     = (phase == 2) ? 49 : (phase == 3) ? 22 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // The sender keeps offering requests through the hold so
                // the block backs up and stalls its input.
                if (phase == 0 && n == RANDOM_PER_PHASE / 2)
                begin
                    hold_req = 1'b1;
                end
                if (phase == 2 && n == RANDOM_PER_PHASE / 2)
                begin
                    wait_drained();
                end
                random_request(((n / 64) % 2) == 0);
            end
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
